// ===== hw/rtl/lpl_pkg.sv =====
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared formats, register codes and reset values of the look-ahead limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

	// configuration register formats
	localparam int CEIL_W    = 24;
	localparam int DELAY_W   = 10;
	localparam int COEF_W    = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [CEIL_W-1:0]  CEIL_RST  = 24'd8388608;
	localparam logic [DELAY_W-1:0] DELAY_RST = 10'd480;
	localparam logic [COEF_W-1:0]  COEF_RST  = 24'd16760000;

	// gain is unsigned Q1.23
	localparam int GAIN_W    = 24;
	localparam int GAIN_FRAC = 23;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h800000;

	// the divider only resolves gains below one, one quotient bit per step
	localparam int QUOT_BITS = GAIN_FRAC;
	localparam int CNT_W     = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CEILING = 2'd0,
		CFG_DELAY   = 2'd1,
		CFG_RELEASE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hw/rtl/lookahead_peak_limiter.sv =====
// ----------------------------------------------------------------------------
// lookahead_peak_limiter
// Peak-envelope limiter applied to a look-ahead delayed sample stream.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  input     in    in_valid / in_stall   sample_in  (signed Q1.23)
//  output    out   out_valid / out_stall sample_out (signed Q1.23)
//  config    in    cfg_we                cfg_index, cfg_data
//
//  A new input waits until the previous result is loaded to the output. The
//  23-step gain divider dominates; a gain saturated at one skips the steps.
//  Reset clears pointer, envelope and controls; the delay memory is not swept,
//  a wrap flag marks entries not yet written, which read back as zero.
//  A result waiting on out_stall does not block the next input transfer; the
//  block holds its finished result only if the output register is still full.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter
	import lpl_pkg::*;
#(
	parameter int DELAY_DEPTH = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int CW = (AW > DELAY_W) ? AW : DELAY_W;
	localparam int PW = SAMPLE_BITS + 26;
	localparam logic [SAMPLE_BITS-1:0] ENV_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ENV    = 6'b000010,
		S_ENVUPD = 6'b000100,
		S_DIV    = 6'b001000,
		S_MUL    = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t state_q;

	logic [CEIL_W-1:0]  ceil_q;
	logic [DELAY_W-1:0] delay_q;
	logic [COEF_W-1:0]  coef_q;

	logic [SAMPLE_BITS-1:0] store_q [DELAY_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_q;

	logic [AW-1:0]          wp_q;
	logic                   wrap_q;
	logic [SAMPLE_BITS-1:0] env_q;
	logic                   div_start_q;
	logic                   out_valid_q;

	logic [SAMPLE_BITS-1:0]        x_q;
	logic [SAMPLE_BITS-1:0]        mag_q;
	logic                          fwd_q;
	logic                          ok_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [PW-1:0]          prod_q;
	logic [SAMPLE_BITS-1:0]        sample_out_q;

	logic                   accept;
	logic                   out_load;
	logic [CW-1:0]          d_ext;
	logic [AW-1:0]          d_cl;
	logic [AW:0]            rp_wrap;
	logic [AW-1:0]          rp;
	logic                   rp_ok;
	logic [SAMPLE_BITS-1:0] mag_in;
	logic [SAMPLE_BITS-1:0] env_diff;
	logic signed [SAMPLE_BITS:0] mul_a;
	logic signed [GAIN_W:0]      mul_b;

	logic [GAIN_W-1:0] gain;
	div_stat_t         div_stat;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// read address: clamp delay to the store, step back from the write pointer
	always_comb begin
		d_ext   = CW'(delay_q);
		d_cl    = (d_ext > CW'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1) : d_ext[AW-1:0];
		rp_wrap = {1'b0, wp_q} + (AW+1)'(DELAY_DEPTH) - {1'b0, d_cl};
		rp      = (wp_q >= d_cl) ? (wp_q - d_cl) : rp_wrap[AW-1:0];
		rp_ok   = wrap_q || (wp_q >= d_cl);
		mag_in  = sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;
	end

	assign env_diff = env_q - mag_q;

	// one shared multiplier: release decay, then the gain product
	always_comb begin
		if (state_q == S_ENV) begin
			mul_a = $signed({1'b0, env_diff});
			mul_b = $signed({1'b0, coef_q});
		end else begin
			mul_a = $signed({y_q[SAMPLE_BITS-1], y_q});
			mul_b = $signed({1'b0, gain});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q  <= CEIL_RST;
			delay_q <= DELAY_RST;
			coef_q  <= COEF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CEILING: ceil_q  <= cfg_data[CEIL_W-1:0];
				CFG_DELAY:   delay_q <= cfg_data[DELAY_W-1:0];
				CFG_RELEASE: coef_q  <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			wrap_q      <= 1'b0;
			env_q       <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (wp_q == AW'(DELAY_DEPTH - 1)) begin
							wp_q   <= '0;
							wrap_q <= 1'b1;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
						state_q <= S_ENV;
					end
				end
				S_ENV: begin
					if (mag_q > env_q) begin
						env_q       <= mag_q;
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end else begin
						state_q <= S_ENVUPD;
					end
				end
				S_ENVUPD: begin
					// mag*2^24 + (env-mag)*c, scaled back by 2^24
					env_q       <= mag_q + prod_q[SAMPLE_BITS+23:24];
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// delay memory: read-before-write, same-entry read forwarded from the input
	always_ff @(posedge clk) begin
		if (accept) begin
			store_q[wp_q] <= sample_in;
			rd_q          <= store_q[rp];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= sample_in;
			mag_q <= mag_in;
			fwd_q <= (d_cl == '0);
			ok_q  <= rp_ok;
		end
		if (state_q == S_ENV) begin
			y_q <= !ok_q ? '0 : (fwd_q ? x_q : rd_q);
		end
		if (state_q == S_ENV || state_q == S_MUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (out_load) begin
			sample_out_q <= prod_q[SAMPLE_BITS+22:23];
		end
	end

	lpl_gain_div #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.ceiling(ceil_q),
		.env    (env_q),
		.gain   (gain),
		.stat   (div_stat)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ENV_MAX)
		else $error("envelope above full-scale magnitude");

	a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_stat.busy)
		else $error("input transfer while divider busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output state");

endmodule

// ===== hw/rtl/lpl_gain_div.sv =====
// ----------------------------------------------------------------------------
// lpl_gain_div
// Iterative gain divider: min(1, ceiling * 2^(SAMPLE_BITS-1) / envelope).
// ----------------------------------------------------------------------------
module lpl_gain_div
	import lpl_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [CEIL_W-1:0]      ceiling,
	input  logic [SAMPLE_BITS-1:0] env,
	output logic [GAIN_W-1:0]      gain,
	output div_stat_t              stat
);

	localparam int NW = CEIL_W + SAMPLE_BITS - 1;

	logic [NW-1:0]          num;
	logic [SAMPLE_BITS-1:0] head;
	logic [SAMPLE_BITS:0]   trial;
	logic [SAMPLE_BITS:0]   trial_sub;
	logic                   trial_ge;

	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [QUOT_BITS-1:0]   low_q;
	logic [QUOT_BITS-1:0]   quot_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   sat_q;
	logic                   busy_q;
	logic                   done_q;

	assign num  = {ceiling, {(SAMPLE_BITS-1){1'b0}}};
	assign head = num[NW-1:QUOT_BITS];

	assign trial     = {rem_q, low_q[QUOT_BITS-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign trial_ge  = (trial >= {1'b0, den_q});

	// a zero envelope also lands in saturation since head >= 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (head >= env) begin
					sat_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					sat_q  <= 1'b0;
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(QUOT_BITS - 1);
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= head;
			den_q  <= env;
			low_q  <= num[QUOT_BITS-1:0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= trial_ge ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
			low_q  <= {low_q[QUOT_BITS-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_BITS-2:0], trial_ge};
		end
	end

	assign gain      = sat_q ? GAIN_ONE : {1'b0, quot_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q)
		else $error("partial remainder reached the divisor");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divide started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q && !busy_q)
		else $error("done held longer than one cycle");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the look-ahead peak limiter. A local model tracks
// the delay line, write pointer and peak envelope and predicts every limited
// sample. A monitor compares each output transfer with the oldest prediction.
// Directed cases cover field and register extremes. Random phases then vary
// the settings, with random input gaps and output stalls outside one calm phase.
// ----------------------------------------------------------------------------
module tb_top
	import lpl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB          = 24;
	localparam int DEPTH       = 1024;
	localparam int SETTLE_CYC  = 40;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ERR_SHOWN   = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic signed [SB-1:0] sample_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [SB-1:0] sample_out;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// limiter model state
	logic signed [SB-1:0]  history [DEPTH];
	logic [9:0]            wr_ptr;
	longint                env_level;
	logic [CEIL_W-1:0]     ceil_q;
	logic [DELAY_W-1:0]    delay_q;
	logic [COEF_W-1:0]     coeff_q;

	logic signed [SB-1:0]  limited_q [$];
	int                    errors = 0;
	int                    cycles = 0;
	bit                    calm   = 1'b0;

	lookahead_peak_limiter #(
		.DELAY_DEPTH(DEPTH),
		.SAMPLE_BITS(SB)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[lookahead_peak_limiter] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 30);
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= ERR_SHOWN)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (limited_q.size() == 0) begin
				flag_error($sformatf("unexpected output transfer: sample_out=%0d", sample_out));
			end else begin
				logic signed [SB-1:0] want;
				want = limited_q.pop_front();
				if (sample_out !== want)
					flag_error($sformatf("sample_out mismatch: expected %0d, got %0d",
						want, sample_out));
			end
		end
	end

	function automatic void model_reset();
		foreach (history[i])
			history[i] = '0;
		wr_ptr    = '0;
		env_level = 0;
		ceil_q    = CEIL_RST;
		delay_q   = DELAY_RST;
		coeff_q   = COEF_RST;
	endfunction

	// advance the envelope and delay line by one sample, return the limited output
	function automatic logic signed [SB-1:0] limit_sample(input logic signed [SB-1:0] x);
		longint               mag;
		longint               gain;
		longint               prod;
		logic signed [SB-1:0] y;
		logic [9:0]           rd_ptr;
		mag = (x < 0) ? -longint'(x) : longint'(x);
		if (mag > env_level)
			env_level = mag;
		else
			env_level = (env_level * longint'(coeff_q)
				+ mag * ((longint'(1) << 24) - longint'(coeff_q))) >>> 24;
		if (env_level == 0) begin
			gain = longint'(GAIN_ONE);
		end else begin
			gain = (longint'(ceil_q) << (SB - 1)) / env_level;
			if (gain > longint'(GAIN_ONE))
				gain = longint'(GAIN_ONE);
		end
		history[wr_ptr] = x;
		rd_ptr = wr_ptr - delay_q;
		y = history[rd_ptr];
		wr_ptr = wr_ptr + 10'd1;
		prod = longint'(y) * gain;
		return SB'(prod >>> GAIN_FRAC);
	endfunction

	task automatic send_sample(input logic signed [SB-1:0] s);
		if (!calm) begin
			while ($urandom_range(0, 99) < 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		do
			@(posedge clk);
		while (in_stall);
		limited_q.push_back(limit_sample(s));
	endtask

	// drop valid, wait for every result, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (limited_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CEILING: ceil_q  = data[CEIL_W-1:0];
			CFG_DELAY:   delay_q = data[DELAY_W-1:0];
			CFG_RELEASE: coeff_q = data[COEF_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic signed [SB-1:0] pick_sample(input int style);
		logic signed [SB-1:0] s;
		case (style)
			0: s = SB'($urandom);
			1: begin
				// quiet program with occasional loud peaks
				if ($urandom_range(0, 99) < 6)
					s = SB'($urandom);
				else
					s = SB'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
			end
			default: begin
				case ($urandom_range(0, 5))
					0: s = {1'b1, {(SB - 1){1'b0}}};
					1: s = {1'b0, {(SB - 1){1'b1}}};
					2: s = '0;
					default: s = SB'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
				endcase
			end
		endcase
		return s;
	endfunction

	task automatic test_reset_state();
		// long default delay: every output reads the cleared delay line
		send_sample(24'sd0);
		send_sample(24'sd8388607);
		send_sample(-24'sd8388608);
	endtask

	task automatic test_zero_delay_extremes();
		settle();
		cfg_write(CFG_DELAY, 24'd0);
		cfg_write(CFG_RELEASE, 24'd0);
		send_sample(24'sd8388607);
		send_sample(-24'sd8388608);
		send_sample(-24'sd1);
		send_sample(24'sd1);
		send_sample(24'sd0);
		send_sample(24'sd4194304);
		send_sample(-24'sd4194304);
	endtask

	task automatic test_ceiling_range();
		settle();
		cfg_write(CFG_CEILING, 24'h200000);
		send_sample(24'sd8388607);
		send_sample(-24'sd8388608);
		send_sample(24'sd1000);
		settle();
		cfg_write(CFG_CEILING, 24'd0);
		send_sample(-24'sd5000);
		settle();
		// ceiling above one: gain still stops at unity
		cfg_write(CFG_CEILING, 24'hFFFFFF);
		send_sample(24'sd8388607);
		send_sample(-24'sd8388608);
	endtask

	task automatic test_release_hold();
		settle();
		cfg_write(CFG_CEILING, 24'h400000);
		cfg_write(CFG_RELEASE, 24'hFFFFFF);
		send_sample(-24'sd8388608);
		send_sample(24'sd100);
		send_sample(-24'sd100);
		send_sample(24'sd3000000);
	endtask

	task automatic test_delay_and_spare_index();
		settle();
		// upper data bits must be dropped for the delay register
		cfg_write(CFG_DELAY, 24'hFFFC03);
		cfg_write(CFG_SPARE, 24'hFFFFFF);
		for (int i = 0; i < 5; i++)
			send_sample(pick_sample(0));
		settle();
		cfg_write(CFG_DELAY, 24'd1023);
		send_sample(24'sd8388607);
		send_sample(pick_sample(0));
	endtask

	task automatic test_random_phases();
		int style;
		for (int ph = 0; ph < 9; ph++) begin
			settle();
			calm = (ph == 3);
			case ($urandom_range(0, 4))
				0: cfg_write(CFG_CEILING, 24'd0);
				1: cfg_write(CFG_CEILING, GAIN_ONE);
				2: cfg_write(CFG_CEILING, 24'hFFFFFF);
				3: cfg_write(CFG_CEILING, CFG_W'($urandom_range(0, 1 << 20)));
				default: cfg_write(CFG_CEILING, CFG_W'($urandom_range(0, 8388608)));
			endcase
			case ($urandom_range(0, 3))
				0: cfg_write(CFG_DELAY, 24'd0);
				1: cfg_write(CFG_DELAY, 24'd1023);
				2: cfg_write(CFG_DELAY, CFG_W'($urandom_range(0, 15)));
				default: cfg_write(CFG_DELAY, CFG_W'($urandom));
			endcase
			case ($urandom_range(0, 3))
				0: cfg_write(CFG_RELEASE, 24'd0);
				1: cfg_write(CFG_RELEASE, 24'hFFFFFF);
				2: cfg_write(CFG_RELEASE, CFG_W'($urandom_range(16000000, 16777215)));
				default: cfg_write(CFG_RELEASE, CFG_W'($urandom));
			endcase
			style = $urandom_range(0, 2);
			for (int i = 0; i < 100; i++)
				send_sample(pick_sample((i % 7 == 0) ? 0 : style));
		end
		calm = 1'b0;
	endtask

	initial begin
		model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_zero_delay_extremes();
		test_ceiling_range();
		test_release_hold();
		test_delay_and_spare_index();
		test_random_phases();
		settle();
		if (errors == 0)
			$display("[lookahead_peak_limiter] OK");
		else
			$display("[lookahead_peak_limiter] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lpl_pkg.sv
hw/rtl/lpl_gain_div.sv
hw/rtl/lookahead_peak_limiter.sv
test/tb_top.sv
